>>> rtl/core/ehi_pkg.sv
// ----------------------------------------------------------------------------
// ehi_pkg
// Shared constants, codes and control types of the extension header inserter.
// ----------------------------------------------------------------------------
package ehi_pkg;

   localparam int MAX_EXT_BYTES_DEF = 56;

   localparam int BYTE_W     = 8;
   localparam int EXT_LEN_W  = 6;
   localparam int LEN_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_NH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATCH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MTU      = 2'd3;

   localparam logic [EXT_LEN_W-1:0] EXT_LEN_RST  = 6'd0;
   localparam logic [BYTE_W-1:0]    NEW_NH_RST   = 8'd0;
   localparam logic [EXT_LEN_W-1:0] PATCH_RST    = 6'd63;
   localparam logic [LEN_W-1:0]     MTU_RST      = 16'd1500;

   localparam logic [LEN_W-1:0]     ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [EXT_LEN_W-1:0] MIN_EXT_LEN    = 6'd8;
   localparam logic [LEN_W-1:0]     MIN_FRAME      = 16'd54;
   localparam logic [LEN_W-1:0]     ETH_HDR_LEN    = 16'd14;

   localparam logic [LEN_W-1:0] POS_TYPE_HI    = 16'd12;
   localparam logic [LEN_W-1:0] POS_TYPE_LO    = 16'd13;
   localparam logic [LEN_W-1:0] POS_LEN_HI     = 16'd18;
   localparam logic [LEN_W-1:0] POS_LEN_LO     = 16'd19;
   localparam logic [LEN_W-1:0] POS_NXT        = 16'd20;
   localparam logic [LEN_W-1:0] POS_BEFORE_INS = 16'd53;
   localparam logic [LEN_W-1:0] POS_INS        = 16'd54;
   localparam logic [LEN_W-1:0] POS_MAX        = 16'hFFFF;

   // number of results an input item causes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_TWO  = 2'd2;
   localparam logic [1:0] KIND_EXT  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic       ext_last;
   } status_type;

   typedef struct packed {
      logic take;
      logic load;
      logic emit_lo;
      logic emit_ext;
   } command_type;

endpackage

>>> rtl/core/ehi_if.sv
// ----------------------------------------------------------------------------
// ehi_if
// Valid/ready channels of the extension header inserter.
// ----------------------------------------------------------------------------
interface ehi_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [ehi_pkg::BYTE_W-1:0]    data_byte;
   logic [ehi_pkg::EXT_LEN_W-1:0] ext_index;
   logic                          last;
   logic [ehi_pkg::LEN_W-1:0]     frame_len;

   modport source (output valid, cmd, data_byte, ext_index, last, frame_len, input ready);
   modport sink   (input valid, cmd, data_byte, ext_index, last, frame_len, output ready);
endinterface

interface ehi_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ehi_pkg::BYTE_W-1:0] out_byte;
   logic                       out_last;
   logic                       inserted;

   modport source (output valid, out_byte, out_last, inserted, input ready);
   modport sink   (input valid, out_byte, out_last, inserted, output ready);
endinterface

interface ehi_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ehi_pkg::CSR_IDX_W-1:0]  index;
   logic [ehi_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ehi_ram.sv
// ----------------------------------------------------------------------------
// ehi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ehi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ehi_dp.sv
// ----------------------------------------------------------------------------
// ehi_dp
// Datapath: frame position, eligibility, header rewrites, extension store
// and the result register.
// ----------------------------------------------------------------------------
module ehi_dp #(
   parameter int MAX_EXT_BYTES = ehi_pkg::MAX_EXT_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_cmd,
   input  logic [ehi_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [ehi_pkg::EXT_LEN_W-1:0]  req_ext_index,
   input  logic                           req_last,
   input  logic [ehi_pkg::LEN_W-1:0]      req_frame_len,
   input  logic                           csr_wr,
   input  logic [ehi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ehi_pkg::CSR_DATA_W-1:0] csr_data,
   input  ehi_pkg::command_type           cmd,
   output ehi_pkg::status_type            sts,
   output logic [ehi_pkg::BYTE_W-1:0]     out_byte,
   output logic                           out_last,
   output logic                           out_inserted
);

   localparam int AW = $clog2(MAX_EXT_BYTES);
   localparam logic [ehi_pkg::EXT_LEN_W-1:0] MAX_EXT = ehi_pkg::EXT_LEN_W'(MAX_EXT_BYTES);

   // configuration
   logic [ehi_pkg::EXT_LEN_W-1:0] ext_len_ff;
   logic [ehi_pkg::BYTE_W-1:0]    new_nh_ff;
   logic [ehi_pkg::EXT_LEN_W-1:0] patch_ff;
   logic [ehi_pkg::LEN_W-1:0]     mtu_ff;

   // frame state
   logic [ehi_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [ehi_pkg::BYTE_W-1:0] type_hi_ff, type_hi_in;
   logic                       elig_ff, elig_in;
   logic [ehi_pkg::BYTE_W-1:0] held_hi_ff, held_hi_in;
   logic [ehi_pkg::BYTE_W-1:0] saved_nh_ff, saved_nh_in;
   logic [AW-1:0]              ext_cnt_ff, ext_cnt_in;

   // payload
   logic [AW-1:0]              cnt_m1_ff;
   logic [ehi_pkg::BYTE_W-1:0] lo_byte_ff;
   logic                       hold_last_ff;
   logic [ehi_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_ins_ff, out_ins_in;

   logic                          frame_take;
   logic                          elig_cond;
   logic                          elig_new;
   logic [ehi_pkg::EXT_LEN_W-1:0] cnt;
   logic [ehi_pkg::LEN_W-1:0]     len_sum;
   logic [ehi_pkg::LEN_W:0]       rel;
   logic                          patch_on;
   logic                          post_patch;
   logic                          ext_patch;
   logic [ehi_pkg::BYTE_W-1:0]    first_byte;
   logic                          first_last;
   logic [1:0]                    kind;
   logic                          ext_last;
   logic                          ram_wr;
   logic [AW-1:0]                 ram_rd_addr;
   logic [ehi_pkg::BYTE_W-1:0]    ram_rd_data;

   assign frame_take = cmd.take && req_cmd;

   assign elig_cond = (type_hi_ff == ehi_pkg::ETHERTYPE_IPV6[15:8])
                   && (req_data_byte == ehi_pkg::ETHERTYPE_IPV6[7:0])
                   && (req_frame_len >= ehi_pkg::MIN_FRAME)
                   && (ext_len_ff >= ehi_pkg::MIN_EXT_LEN)
                   && (ext_len_ff <= MAX_EXT)
                   && ((17'(req_frame_len - ehi_pkg::ETH_HDR_LEN) + 17'(ext_len_ff))
                       <= 17'(mtu_ff));

   assign elig_new   = (pos_ff == ehi_pkg::POS_TYPE_LO) ? elig_cond : elig_ff;
   assign cnt        = (ext_len_ff > MAX_EXT) ? MAX_EXT : ext_len_ff;
   assign len_sum    = {held_hi_ff, req_data_byte} + ehi_pkg::LEN_W'(ext_len_ff);
   assign rel        = 17'(ext_len_ff) + 17'(pos_ff - ehi_pkg::POS_INS);
   assign patch_on   = patch_ff < MAX_EXT;
   assign post_patch = patch_on && (rel == 17'(patch_ff));
   assign ext_patch  = patch_on && (ehi_pkg::EXT_LEN_W'(ext_cnt_ff) == patch_ff);
   assign ext_last   = ext_cnt_ff == cnt_m1_ff;

   // first result of the current item
   always_comb begin
      first_byte = req_data_byte;
      first_last = req_last;
      kind       = ehi_pkg::KIND_ONE;
      priority if (!req_cmd) begin
         kind = ehi_pkg::KIND_NONE;
      end else if (!elig_new) begin
         kind = ehi_pkg::KIND_ONE;
      end else if (pos_ff == ehi_pkg::POS_LEN_HI) begin
         if (!req_last) begin
            kind = ehi_pkg::KIND_NONE;
         end
      end else if (pos_ff == ehi_pkg::POS_LEN_LO) begin
         first_byte = len_sum[15:8];
         first_last = 1'b0;
         kind       = ehi_pkg::KIND_TWO;
      end else if (pos_ff == ehi_pkg::POS_NXT) begin
         first_byte = new_nh_ff;
      end else if (pos_ff == ehi_pkg::POS_BEFORE_INS) begin
         if (cnt != '0) begin
            first_last = 1'b0;
            kind       = ehi_pkg::KIND_EXT;
         end
      end else if (pos_ff >= ehi_pkg::POS_INS) begin
         if (post_patch) begin
            first_byte = saved_nh_ff;
         end
      end else begin
         kind = ehi_pkg::KIND_ONE;
      end
   end

   assign sts.kind     = kind;
   assign sts.ext_last = ext_last;

   // frame state update
   always_comb begin
      pos_in      = pos_ff;
      type_hi_in  = type_hi_ff;
      elig_in     = elig_ff;
      held_hi_in  = held_hi_ff;
      saved_nh_in = saved_nh_ff;
      if (frame_take) begin
         if (pos_ff == ehi_pkg::POS_TYPE_HI) begin
            type_hi_in = req_data_byte;
         end
         elig_in = elig_new;
         if (elig_new && pos_ff == ehi_pkg::POS_LEN_HI) begin
            held_hi_in = req_data_byte;
         end
         if (elig_new && pos_ff == ehi_pkg::POS_NXT) begin
            saved_nh_in = req_data_byte;
         end
         if (req_last) begin
            pos_in     = '0;
            elig_in    = 1'b0;
            type_hi_in = '0;
            held_hi_in = '0;
         end else if (pos_ff != ehi_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_comb begin
      ext_cnt_in = ext_cnt_ff;
      if (cmd.emit_ext) begin
         ext_cnt_in = ext_last ? '0 : ext_cnt_ff + AW'(1);
      end
   end

   always_comb begin
      priority if (cmd.emit_lo) begin
         out_byte_in = lo_byte_ff;
         out_last_in = hold_last_ff;
         out_ins_in  = 1'b1;
      end else if (cmd.emit_ext) begin
         out_byte_in = ext_patch ? saved_nh_ff : ram_rd_data;
         out_last_in = ext_last && hold_last_ff;
         out_ins_in  = 1'b1;
      end else begin
         out_byte_in = first_byte;
         out_last_in = first_last;
         out_ins_in  = elig_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_len_ff  <= ehi_pkg::EXT_LEN_RST;
         new_nh_ff   <= ehi_pkg::NEW_NH_RST;
         patch_ff    <= ehi_pkg::PATCH_RST;
         mtu_ff      <= ehi_pkg::MTU_RST;
         pos_ff      <= '0;
         type_hi_ff  <= '0;
         elig_ff     <= 1'b0;
         held_hi_ff  <= '0;
         saved_nh_ff <= '0;
         ext_cnt_ff  <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               ehi_pkg::CSR_EXT_LEN: ext_len_ff <= csr_data[ehi_pkg::EXT_LEN_W-1:0];
               ehi_pkg::CSR_NEW_NH:  new_nh_ff  <= csr_data[ehi_pkg::BYTE_W-1:0];
               ehi_pkg::CSR_PATCH:   patch_ff   <= csr_data[ehi_pkg::EXT_LEN_W-1:0];
               ehi_pkg::CSR_MTU:     mtu_ff     <= csr_data;
            endcase
         end
         pos_ff      <= pos_in;
         type_hi_ff  <= type_hi_in;
         elig_ff     <= elig_in;
         held_hi_ff  <= held_hi_in;
         saved_nh_ff <= saved_nh_in;
         ext_cnt_ff  <= ext_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_take) begin
         hold_last_ff <= req_last;
         lo_byte_ff   <= len_sum[7:0];
         if (pos_ff == ehi_pkg::POS_BEFORE_INS) begin
            cnt_m1_ff <= AW'(cnt - 6'd1);
         end
      end
      if (cmd.load) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_ins_ff  <= out_ins_in;
      end
   end

   // extension store
   assign ram_wr      = cmd.take && !req_cmd && (req_ext_index < MAX_EXT);
   assign ram_rd_addr = (cmd.emit_ext && !ext_last) ? ext_cnt_ff + AW'(1) : ext_cnt_ff;

   ehi_ram #(
      .WIDTH (ehi_pkg::BYTE_W),
      .DEPTH (MAX_EXT_BYTES)
   ) u_ext_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (req_ext_index[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_byte     = out_byte_ff;
   assign out_last     = out_last_ff;
   assign out_inserted = out_ins_ff;

   a_pos_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      frame_take && req_last |=> pos_ff == '0 && !elig_ff)
      else $error("position not cleared after frame end");

   a_ext_cnt_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_ext && ext_last |=> ext_cnt_ff == '0)
      else $error("extension counter not returned to zero");

endmodule

>>> rtl/core/ehi_ctrl.sv
// ----------------------------------------------------------------------------
// ehi_ctrl
// Controller: input handshake, result register valid, the low length byte and
// the extension emission sequence.
// ----------------------------------------------------------------------------
module ehi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ehi_pkg::status_type  sts,
   output ehi_pkg::command_type cmd
);

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_LEN_LO = 2'd1;
   localparam logic [1:0] ST_EXT    = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = out_free;
            cmd.take  = req_valid && out_free;
            if (cmd.take) begin
               unique case (sts.kind)
                  ehi_pkg::KIND_NONE: begin
                     cmd.load = 1'b0;
                  end
                  ehi_pkg::KIND_ONE: begin
                     cmd.load = 1'b1;
                  end
                  ehi_pkg::KIND_TWO: begin
                     cmd.load = 1'b1;
                     state_in = ST_LEN_LO;
                  end
                  ehi_pkg::KIND_EXT: begin
                     cmd.load = 1'b1;
                     state_in = ST_EXT;
                  end
               endcase
            end
         end
         ST_LEN_LO: begin
            if (out_free) begin
               cmd.emit_lo = 1'b1;
               cmd.load    = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_EXT: begin
            if (out_free) begin
               cmd.emit_ext = 1'b1;
               cmd.load     = 1'b1;
               if (sts.ext_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while full");

   a_two_results: assert property (@(posedge clock) disable iff (reset)
      cmd.take && sts.kind == ehi_pkg::KIND_TWO |=> state_ff == ST_LEN_LO)
      else $error("low length byte not scheduled");

   a_ext_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXT && out_free && sts.ext_last |=> state_ff == ST_RUN)
      else $error("extension sequence did not finish");

endmodule

>>> rtl/core/ipv6_extension_header_inserter.sv
// ----------------------------------------------------------------------------
// ipv6_extension_header_inserter
// Inserts a stored extension header into eligible IPv6 frames of a byte stream.
// ----------------------------------------------------------------------------
// An item on req_if is either an extension byte load (cmd 0) or one frame byte
// (cmd 1). Loads and most frame bytes are taken back to back while rsp_if keeps
// taking results from the single result register. In an eligible frame, byte
// 18 is held and gives no result, byte 19 gives two results (both length bytes),
// and byte 53 gives its own result followed by ext_len extension bytes, read out
// of the extension RAM one per cycle while rsp_if takes them. No new item is
// taken while those extra results are being emitted. Configuration writes on
// csr_if are taken in any cycle.
module ipv6_extension_header_inserter #(
   parameter int MAX_EXT_BYTES = ehi_pkg::MAX_EXT_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ehi_req_if.sink    req_if,
   ehi_rsp_if.source  rsp_if,
   ehi_csr_if.sink    csr_if
);

   ehi_pkg::command_type cmd;
   ehi_pkg::status_type  sts;

   assign csr_if.ready = 1'b1;

   ehi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ehi_dp #(
      .MAX_EXT_BYTES (MAX_EXT_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_if.cmd),
      .req_data_byte (req_if.data_byte),
      .req_ext_index (req_if.ext_index),
      .req_last      (req_if.last),
      .req_frame_len (req_if.frame_len),
      .csr_wr        (csr_if.valid),
      .csr_index     (csr_if.index),
      .csr_data      (csr_if.data),
      .cmd           (cmd),
      .sts           (sts),
      .out_byte      (rsp_if.out_byte),
      .out_last      (rsp_if.out_last),
      .out_inserted  (rsp_if.inserted)
   );

endmodule
